// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros used by the rtl file chunk_header_parser_unit
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chp: same-cycle check failed");

// next-cycle implication, checked outside reset
`define CHP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chp: next-cycle check failed");

`endif

// ===== rtl/chp_pkg.sv =====
// ---------------------------------------------------------------------------
// chp_pkg
// widths, format codes and helpers for the chunk header parser
// ---------------------------------------------------------------------------
package chp_pkg;

  localparam int DATA_W = 8;
  localparam int FMT_W  = 2;
  localparam int CHAN_W = 17;
  localparam int TS_W   = 32;
  localparam int LEN_W  = 24;
  localparam int KIND_W = 8;
  localparam int SID_W  = 32;
  localparam int HSZ_W  = 4;
  localparam int POS_W  = 5;

  typedef logic [FMT_W-1:0] fmt_t;

  localparam fmt_t FMT_NEW      = 2'd0;
  localparam fmt_t FMT_SAME_SRC = 2'd1;
  localparam fmt_t FMT_TIMER    = 2'd2;
  localparam fmt_t FMT_CONT     = 2'd3;

  // channel codes that escape to a longer channel id
  localparam logic [5:0] CODE_ESC2 = 6'd0;
  localparam logic [5:0] CODE_ESC3 = 6'd1;

  localparam logic [CHAN_W-1:0] CHAN_BASE = 17'd64;
  localparam logic [LEN_W-1:0]  ESC_MARK  = 24'hFFFFFF;
  localparam logic [POS_W-1:0]  POS_LAST  = 5'd17;

  // body bytes that follow the basic header
  function automatic logic [HSZ_W-1:0] body_size(input fmt_t f);
    logic [HSZ_W-1:0] n;
    case (f)
      FMT_NEW:      n = 4'd11;
      FMT_SAME_SRC: n = 4'd7;
      FMT_TIMER:    n = 4'd3;
      default:      n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/chp_byte_if.sv =====
// ---------------------------------------------------------------------------
// chp_byte_if
// byte stream channel into the parser
// ---------------------------------------------------------------------------
interface chp_byte_if import chp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/chp_hdr_if.sv =====
// ---------------------------------------------------------------------------
// chp_hdr_if
// decoded chunk header channel out of the parser
// ---------------------------------------------------------------------------
interface chp_hdr_if import chp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FMT_W-1:0]  fmt_type;
  logic [CHAN_W-1:0] chunk_channel;
  logic [TS_W-1:0]   abs_timestamp;
  logic [LEN_W-1:0]  msg_length;
  logic [KIND_W-1:0] msg_kind;
  logic [SID_W-1:0]  stream_ident;
  logic [HSZ_W-1:0]  hdr_bytes;
  logic              ext_flag;

  modport source (output valid, output fmt_type, output chunk_channel,
                  output abs_timestamp, output msg_length, output msg_kind,
                  output stream_ident, output hdr_bytes, output ext_flag,
                  input ready);
  modport sink   (input valid, input fmt_type, input chunk_channel,
                  input abs_timestamp, input msg_length, input msg_kind,
                  input stream_ident, input hdr_bytes, input ext_flag,
                  output ready);
endinterface

// ===== rtl/chunk_header_parser_unit.sv =====
// ---------------------------------------------------------------------------
// chunk_header_parser_unit
// rtmp chunk header parser, one header byte per item
// ---------------------------------------------------------------------------
// Takes one byte per cycle with no gaps required. Each byte is captured in an
// input register and from there updates the position counter and the kept
// header fields in a single step; a completed header lands in the output
// register in that same step. The per-byte step (channel decode, field
// assembly, 32-bit timestamp add) sets the one-byte-per-cycle rate. The input
// side keeps taking bytes while a result waits, until that result blocks the
// next completed header. There is no resync: every byte belongs to the
// current header.
`include "assert_macros.svh"

module chunk_header_parser_unit import chp_pkg::*; (
  input logic        clk,
  input logic        rst,
  chp_byte_if.sink   byte_ch,
  chp_hdr_if.source  hdr_ch
);

  // input stage
  logic              in_vld;
  logic [DATA_W-1:0] byte_q;

  // parse state
  logic [POS_W-1:0]  pos, pos_next;
  fmt_t              cur_fmt, cur_fmt_next;
  logic [1:0]        chb, chb_next;
  logic [CHAN_W-1:0] chw, chw_next;
  logic [31:0]       asm_r, asm_next;
  logic [TS_W-1:0]   kept_ts, kept_ts_next;
  logic [TS_W-1:0]   kept_delta, kept_delta_next;
  logic [LEN_W-1:0]  kept_len, kept_len_next;
  logic [KIND_W-1:0] kept_kind, kept_kind_next;
  logic [SID_W-1:0]  kept_sid, kept_sid_next;
  logic              kept_ext, kept_ext_next;

  // output register
  logic              out_vld;
  fmt_t              fmt_q;
  logic [CHAN_W-1:0] chan_q;
  logic [TS_W-1:0]   ts_q;
  logic [LEN_W-1:0]  len_q;
  logic [KIND_W-1:0] kind_q;
  logic [SID_W-1:0]  sid_q;
  logic [HSZ_W-1:0]  hsz_q;
  logic              ext_q;

  logic              adv;
  logic              done;
  logic [POS_W-1:0]  off;
  logic [POS_W-1:0]  ext_idx;
  logic [HSZ_W-1:0]  base;
  logic [HSZ_W-1:0]  hsz;
  logic [31:0]       be;
  logic [5:0]        code;

  // only a byte that completes a header needs the output register free
  assign adv          = in_vld && (!done || !out_vld || hdr_ch.ready);
  assign byte_ch.ready = !in_vld || adv;

  always_comb begin
    pos_next        = pos + 5'd1;
    cur_fmt_next    = cur_fmt;
    chb_next        = chb;
    chw_next        = chw;
    asm_next        = asm_r;
    kept_ts_next    = kept_ts;
    kept_delta_next = kept_delta;
    kept_len_next   = kept_len;
    kept_kind_next  = kept_kind;
    kept_sid_next   = kept_sid;
    kept_ext_next   = kept_ext;
    done            = 1'b0;
    code            = byte_q[5:0];
    be              = {asm_r[23:0], byte_q};
    off             = pos - {3'b000, chb};
    ext_idx         = off - {1'b0, body_size(cur_fmt)};

    if (pos == '0) begin
      cur_fmt_next = byte_q[7:6];
      if (code == CODE_ESC2 || code == CODE_ESC3) begin
        chb_next = code[1:0] + 2'd2;
        chw_next = CHAN_BASE;
      end else begin
        chb_next = 2'd1;
        chw_next = {11'd0, code};
      end
    end else if (pos < {3'b000, chb}) begin
      if (pos == 5'd1) begin
        chw_next = chw + {9'd0, byte_q};
      end else begin
        chw_next = chw + {1'b0, byte_q, 8'd0};
      end
    end else if (off < {1'b0, body_size(cur_fmt)}) begin
      case (cur_fmt)
        FMT_NEW: begin
          if (off inside {[0:2]}) begin
            asm_next = be;
            if (off == 5'd2) kept_ts_next = {8'd0, be[23:0]};
          end else if (off inside {[3:5]}) begin
            asm_next = be;
            if (off == 5'd5) kept_len_next = be[23:0];
          end else if (off == 5'd6) begin
            kept_kind_next = byte_q;
          end else begin
            // stream id arrives little-endian
            asm_next = {byte_q, asm_r[31:8]};
            if (off == 5'd10) kept_sid_next = asm_next;
          end
        end
        FMT_SAME_SRC: begin
          if (off inside {[0:2]}) begin
            asm_next = be;
            if (off == 5'd2) kept_delta_next = {8'd0, be[23:0]};
          end else if (off inside {[3:5]}) begin
            asm_next = be;
            if (off == 5'd5) kept_len_next = be[23:0];
          end else begin
            kept_kind_next = byte_q;
          end
        end
        default: begin
          asm_next = be;
          if (off == 5'd2) kept_delta_next = {8'd0, be[23:0]};
        end
      endcase
    end else begin
      // extended timestamp bytes
      asm_next = be;
      if (ext_idx == 5'd3) begin
        if (cur_fmt == FMT_SAME_SRC || cur_fmt == FMT_TIMER) begin
          kept_delta_next = asm_next;
        end else begin
          kept_ts_next = asm_next;
        end
        done = 1'b1;
      end
    end

    base = body_size(cur_fmt_next);
    hsz  = {2'b00, chb_next} + base;

    if (pos_next == {1'b0, hsz}) begin
      if (cur_fmt_next == FMT_NEW) begin
        kept_delta_next = '0;
        kept_ext_next   = (kept_ts_next == {8'd0, ESC_MARK});
      end else if (cur_fmt_next != FMT_CONT) begin
        kept_ext_next = (kept_delta_next == {8'd0, ESC_MARK});
      end
      if (!kept_ext_next) done = 1'b1;
    end

    if (done) begin
      if (cur_fmt_next == FMT_SAME_SRC || cur_fmt_next == FMT_TIMER) begin
        kept_ts_next = kept_ts_next + kept_delta_next;
      end
      pos_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (byte_ch.valid && byte_ch.ready) begin
      in_vld <= 1'b1;
    end else if (adv) begin
      in_vld <= 1'b0;
    end
    if (byte_ch.valid && byte_ch.ready) byte_q <= byte_ch.data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      cur_fmt    <= FMT_NEW;
      chb        <= '0;
      chw        <= '0;
      asm_r      <= '0;
      kept_ts    <= '0;
      kept_delta <= '0;
      kept_len   <= '0;
      kept_kind  <= '0;
      kept_sid   <= '0;
      kept_ext   <= 1'b0;
    end else if (adv) begin
      pos        <= pos_next;
      cur_fmt    <= cur_fmt_next;
      chb        <= chb_next;
      chw        <= chw_next;
      asm_r      <= asm_next;
      kept_ts    <= kept_ts_next;
      kept_delta <= kept_delta_next;
      kept_len   <= kept_len_next;
      kept_kind  <= kept_kind_next;
      kept_sid   <= kept_sid_next;
      kept_ext   <= kept_ext_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv && done) begin
      out_vld <= 1'b1;
    end else if (hdr_ch.ready) begin
      out_vld <= 1'b0;
    end
    if (adv && done) begin
      fmt_q  <= cur_fmt_next;
      chan_q <= chw_next;
      ts_q   <= kept_ts_next;
      len_q  <= kept_len_next;
      kind_q <= kept_kind_next;
      sid_q  <= kept_sid_next;
      hsz_q  <= hsz;
      ext_q  <= kept_ext_next;
    end
  end

  assign hdr_ch.valid         = out_vld;
  assign hdr_ch.fmt_type      = fmt_q;
  assign hdr_ch.chunk_channel = chan_q;
  assign hdr_ch.abs_timestamp = ts_q;
  assign hdr_ch.msg_length    = len_q;
  assign hdr_ch.msg_kind      = kind_q;
  assign hdr_ch.stream_ident  = sid_q;
  assign hdr_ch.hdr_bytes     = hsz_q;
  assign hdr_ch.ext_flag      = ext_q;

  `CHP_ASSERT_IMP(a_pos_range, 1'b1, pos <= POS_LAST)
  `CHP_ASSERT_IMP(a_chan_len_set, pos != '0, chb != '0)
  `CHP_ASSERT_NXT(a_done_restarts, adv && done, pos == '0)
  `CHP_ASSERT_NXT(a_in_held, in_vld && !adv, in_vld && $stable(byte_q))
  `CHP_ASSERT_IMP(a_hsz_nonzero, out_vld, hsz_q != '0)

endmodule

// ===== tb/tb_chunk_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// tb_chunk_header_parser_unit
// Feeds chunk header byte streams into the parser and checks each decoded
// header against a cycle-free model of the parser state. Directed headers
// cover the field extremes, then random well-formed headers with some noise
// run under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_chunk_header_parser_unit import chp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    fmt_t              fmt;
    logic [CHAN_W-1:0] chan;
    logic [TS_W-1:0]   ts;
    logic [LEN_W-1:0]  len;
    logic [KIND_W-1:0] kind;
    logic [SID_W-1:0]  sid;
    logic [HSZ_W-1:0]  hsz;
    logic              ext;
  } chunk_hdr_t;

  logic clk = 1'b0;
  logic rst;

  chp_byte_if byte_ch ();
  chp_hdr_if  hdr_ch ();

  chunk_header_parser_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .byte_ch(byte_ch),
    .hdr_ch (hdr_ch)
  );

  always #5 clk = ~clk;

  logic [DATA_W-1:0] pending_bytes[$];
  chunk_hdr_t        expected_hdrs[$];
  int                stim_count = 0;
  int                error_count = 0;
  int                cycle_count = 0;
  int                send_idle_pct = 14;
  int                recv_stall_pct = 66;
  logic              stream_ext_pending = 1'b0;

  // parser state as seen from the byte stream
  logic [POS_W-1:0]  hdr_pos = '0;
  fmt_t              hdr_fmt = FMT_NEW;
  logic [1:0]        hdr_chan_len = '0;
  logic [CHAN_W-1:0] hdr_chan = '0;
  logic [31:0]       hdr_asm = '0;
  logic [TS_W-1:0]   hdr_ts = '0;
  logic [TS_W-1:0]   hdr_delta = '0;
  logic [LEN_W-1:0]  hdr_len = '0;
  logic [KIND_W-1:0] hdr_kind = '0;
  logic [SID_W-1:0]  hdr_sid = '0;
  logic              hdr_ext = 1'b0;

  function automatic logic [HSZ_W-1:0] hdr_body_len(input fmt_t f);
    case (f)
      FMT_NEW:      return 4'd11;
      FMT_SAME_SRC: return 4'd7;
      FMT_TIMER:    return 4'd3;
      default:      return 4'd0;
    endcase
  endfunction

  // advance the parser state by one byte, returns 1 when a header completes
  function automatic bit parse_byte(input logic [DATA_W-1:0] b, output chunk_hdr_t h);
    logic [5:0]       code;
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] nxt;
    logic [HSZ_W-1:0] body;
    logic [31:0]      be;
    bit               done;
    done = 1'b0;
    h = '0;
    if (hdr_pos == 0) begin
      code = b[5:0];
      hdr_fmt = fmt_t'(b[7:6]);
      if (code == CODE_ESC2 || code == CODE_ESC3) begin
        hdr_chan_len = 2'(code + 6'd2);
        hdr_chan = CHAN_BASE;
      end else begin
        hdr_chan_len = 2'd1;
        hdr_chan = CHAN_W'(code);
      end
    end else if (hdr_pos < POS_W'(hdr_chan_len)) begin
      if (hdr_pos == 1) hdr_chan = hdr_chan + CHAN_W'(b);
      else hdr_chan = hdr_chan + CHAN_W'({b, 8'h00});
    end else begin
      off = hdr_pos - POS_W'(hdr_chan_len);
      body = hdr_body_len(hdr_fmt);
      be = {hdr_asm[23:0], b};
      if (off < POS_W'(body)) begin
        case (hdr_fmt)
          FMT_NEW: begin
            if (off < 3) begin
              hdr_asm = be;
              if (off == 2) hdr_ts = {8'h00, be[23:0]};
            end else if (off < 6) begin
              hdr_asm = be;
              if (off == 5) hdr_len = be[23:0];
            end else if (off == 6) begin
              hdr_kind = b;
            end else begin
              // stream id is little-endian
              hdr_asm = {b, hdr_asm[31:8]};
              if (off == 10) hdr_sid = hdr_asm;
            end
          end
          FMT_SAME_SRC: begin
            if (off < 3) begin
              hdr_asm = be;
              if (off == 2) hdr_delta = {8'h00, be[23:0]};
            end else if (off < 6) begin
              hdr_asm = be;
              if (off == 5) hdr_len = be[23:0];
            end else begin
              hdr_kind = b;
            end
          end
          default: begin
            hdr_asm = be;
            if (off == 2) hdr_delta = {8'h00, be[23:0]};
          end
        endcase
      end else begin
        // extended timestamp bytes
        hdr_asm = be;
        if (off - POS_W'(body) == 3) begin
          if (hdr_fmt == FMT_SAME_SRC || hdr_fmt == FMT_TIMER) hdr_delta = hdr_asm;
          else hdr_ts = hdr_asm;
          done = 1'b1;
        end
      end
    end

    body = hdr_body_len(hdr_fmt);
    nxt = hdr_pos + 1'b1;
    if (nxt == POS_W'(hdr_chan_len) + POS_W'(body)) begin
      if (hdr_fmt == FMT_NEW) begin
        hdr_delta = '0;
        hdr_ext = (hdr_ts == {8'h00, ESC_MARK});
      end else if (hdr_fmt != FMT_CONT) begin
        hdr_ext = (hdr_delta == {8'h00, ESC_MARK});
      end
      if (!hdr_ext) done = 1'b1;
    end

    if (!done) begin
      hdr_pos = nxt;
      return 1'b0;
    end

    if (hdr_fmt == FMT_SAME_SRC || hdr_fmt == FMT_TIMER) hdr_ts = hdr_ts + hdr_delta;
    hdr_pos = '0;
    h.fmt  = hdr_fmt;
    h.chan = hdr_chan;
    h.ts   = hdr_ts;
    h.len  = hdr_len;
    h.kind = hdr_kind;
    h.sid  = hdr_sid;
    h.hsz  = HSZ_W'(hdr_chan_len) + body;
    h.ext  = hdr_ext;
    return 1'b1;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      byte_ch.data_byte <= '0;
    end else if (!byte_ch.valid || byte_ch.ready) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= pending_bytes.pop_front();
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) hdr_ch.ready <= 1'b0;
    else hdr_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: predict on accepted bytes, compare accepted headers
  always @(posedge clk) begin : monitor
    chunk_hdr_t want;
    chunk_hdr_t got;
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) begin
        if (parse_byte(byte_ch.data_byte, want)) expected_hdrs.push_back(want);
      end
      if (hdr_ch.valid && hdr_ch.ready) begin
        got.fmt  = fmt_t'(hdr_ch.fmt_type);
        got.chan = hdr_ch.chunk_channel;
        got.ts   = hdr_ch.abs_timestamp;
        got.len  = hdr_ch.msg_length;
        got.kind = hdr_ch.msg_kind;
        got.sid  = hdr_ch.stream_ident;
        got.hsz  = hdr_ch.hdr_bytes;
        got.ext  = hdr_ch.ext_flag;
        if (expected_hdrs.size() == 0) begin
          report_error("header item with none expected");
        end else begin
          want = expected_hdrs.pop_front();
          check_field("fmt_type", 32'(got.fmt), 32'(want.fmt));
          check_field("chunk_channel", 32'(got.chan), 32'(want.chan));
          check_field("abs_timestamp", got.ts, want.ts);
          check_field("msg_length", 32'(got.len), 32'(want.len));
          check_field("msg_kind", 32'(got.kind), 32'(want.kind));
          check_field("stream_ident", got.sid, want.sid);
          check_field("hdr_bytes", 32'(got.hsz), 32'(want.hsz));
          check_field("ext_flag", 32'(got.ext), 32'(want.ext));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_byte(input logic [DATA_W-1:0] b);
    pending_bytes.push_back(b);
    stim_count++;
  endtask

  task automatic push_be(input logic [31:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) push_byte(v[i*8 +: 8]);
  endtask

  task automatic emit_header(input fmt_t f, input int nch, input logic [5:0] code,
                             input logic [15:0] long_id, input logic [23:0] t24,
                             input logic [31:0] t_ext, input logic [23:0] len,
                             input logic [7:0] kind, input logic [31:0] sid);
    logic [5:0] first_code;
    first_code = (nch == 1) ? code : ((nch == 2) ? CODE_ESC2 : CODE_ESC3);
    push_byte({f, first_code});
    if (nch >= 2) push_byte(long_id[7:0]);
    if (nch == 3) push_byte(long_id[15:8]);
    if (f != FMT_CONT) begin
      push_be({8'h00, t24}, 3);
      stream_ext_pending = (t24 == ESC_MARK);
    end
    if (f == FMT_NEW || f == FMT_SAME_SRC) begin
      push_be({8'h00, len}, 3);
      push_byte(kind);
    end
    if (f == FMT_NEW) begin
      for (int i = 0; i < 4; i++) push_byte(sid[i*8 +: 8]);
    end
    if (stream_ext_pending) push_be(t_ext, 4);
  endtask

  task automatic emit_random_header();
    int         nch;
    int         pick;
    logic [23:0] t24;
    pick = $urandom_range(99);
    nch = (pick < 60) ? 1 : ((pick < 80) ? 2 : 3);
    t24 = ($urandom_range(99) < 25) ? ESC_MARK : 24'($urandom);
    emit_header(fmt_t'($urandom_range(3)), nch, 6'($urandom_range(63, 2)), 16'($urandom),
                t24, $urandom, 24'($urandom), 8'($urandom), $urandom);
  endtask

  task automatic wait_sent();
    do @(negedge clk); while (pending_bytes.size() != 0 || byte_ch.valid);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || byte_ch.valid || expected_hdrs.size() != 0);
  endtask

  // garbage or a cut-off header, then pad until the parser is back at a boundary
  task automatic emit_noise();
    int cut;
    if ($urandom_range(1) == 0) begin
      emit_random_header();
      cut = $urandom_range(3, 1);
      for (int i = 0; i < cut; i++) void'(pending_bytes.pop_back());
      stim_count -= cut;
    end else begin
      repeat ($urandom_range(16, 1)) push_byte(8'($urandom));
    end
    wait_sent();
    while (hdr_pos != 0) begin
      push_byte(8'($urandom));
      wait_sent();
    end
    stream_ext_pending = hdr_ext;
  endtask

  initial begin
    int phase_end;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // all-ones fields with extended timestamp, largest 1-byte channel
    emit_header(FMT_NEW, 1, 6'h3f, 16'h0000, ESC_MARK, 32'hFFFF_FFFF, 24'hFF_FFFF,
                8'hFF, 32'hFFFF_FFFF);
    // 2-byte channel, delta wraps the timestamp past 2^32
    emit_header(FMT_TIMER, 2, 6'd0, 16'h00FF, 24'h000001, 32'h0, 24'h0, 8'h0, 32'h0);
    // largest 3-byte channel, no extended bytes
    emit_header(FMT_CONT, 3, 6'd0, 16'hFFFF, 24'h0, 32'h0, 24'h0, 8'h0, 32'h0);
    // smallest channel, zero fields
    emit_header(FMT_SAME_SRC, 1, 6'd2, 16'h0000, 24'h0, 32'h0, 24'h0, 8'h0, 32'h0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_stall_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_stall_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      phase_end = stim_count + 270;
      while (stim_count < phase_end) begin
        if ($urandom_range(99) < 10) emit_noise();
        else emit_random_header();
      end
      // sender holds off until every header is back
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
